// ===== rtl/swm_pkg.sv =====
package swm_pkg;

    // Sizes
    localparam int WIN_MAX  = 64;                   // largest supported window
    localparam int SAMPLE_W = 32;                   // sample width, two's complement
    localparam int WS_W     = 7;                    // width of the window size register
    localparam int CNT_W    = $clog2(WIN_MAX + 1);  // counters that reach WIN_MAX
    localparam int NCELL    = WIN_MAX - 1;          // suffix maxima kept in the chain
    localparam int IDX_W    = $clog2(NCELL);        // cell select width

    localparam logic [WS_W-1:0] WS_RESET = WS_W'(3);

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // Control handed from the top level to the cell row
    typedef struct packed {
        logic             shift;  // a word is taken this cycle
        logic [IDX_W-1:0] sel;    // cell whose old value feeds the result
    } swm_ctl_t;

    // Signed maximum
    function automatic sample_t smax(input sample_t a, input sample_t b);
        smax = (a > b) ? a : b;
    endfunction

endpackage

// ===== rtl/swm_cell.sv =====
// One cell: holds the maximum of the last (k+1) samples for its place k.
module swm_cell
    import swm_pkg::*;
(
    input  logic    clk,
    input  logic    shift,
    input  sample_t x,
    input  sample_t prev_max,
    output sample_t max_q
);

    sample_t max_reg;
    sample_t max_next;

    // New suffix max: neighbor's old value merged with the incoming sample
    assign max_next = smax(prev_max, x);

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            max_reg <= max_next;
        end
    end

    assign max_q = max_reg;

endmodule

// ===== rtl/swm_chain.sv =====
// Row of suffix-max cells plus the one-hot tap that reads a chosen cell.
module swm_chain
    import swm_pkg::*;
(
    input  logic     clk,
    input  swm_ctl_t ctl,
    input  sample_t  x,
    output sample_t  tap
);

    sample_t cell_q [NCELL];

    // Cell 0 sees the sample itself, so it just stores it
    genvar k;
    generate
        for (k = 0; k < NCELL; k++)
        begin : g_cell
            sample_t prev;
            if (k == 0)
            begin : g_first
                assign prev = x;
            end
            else
            begin : g_rest
                assign prev = cell_q[k-1];
            end
            swm_cell u_cell (
                .clk      (clk),
                .shift    (ctl.shift),
                .x        (x),
                .prev_max (prev),
                .max_q    (cell_q[k])
            );
        end
    endgenerate

    // AND-OR select of the old value at the chosen place
    always_comb
    begin
        tap = '0;
        for (int i = 0; i < NCELL; i++)
        begin
            if (ctl.sel == IDX_W'(i))
            begin
                tap = tap | cell_q[i];
            end
        end
    end

endmodule

// ===== rtl/sliding_window_maximum_unit.sv =====
// Sliding window maximum over a stream of signed 32-bit samples. One word is
// taken every cycle; any result is registered in the output register, and the
// input stalls only while that register is full and the output side stalls. A
// row of 63 cells keeps the running maxima of the last 1..63 samples; each
// cell does one signed compare per word, so the rate is set by a single
// compare plus the cell select. A result appears once window_size samples have
// arrived since reset or restart; window_size 0 acts as 1, values above 64 act
// as 64. Write window_size through the config channel only while the block is
// idle; the block does not enforce it. No clearing pass follows reset.
module sliding_window_maximum_unit
    import swm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // input words
    input  logic                in_valid,
    output logic                in_stall,
    input  sample_t             sample,
    input  logic                restart,
    // result words
    output logic                out_valid,
    input  logic                out_stall,
    output sample_t             window_max,
    // config
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [WS_W-1:0]     window_size
);

    logic [WS_W-1:0]  ws_reg;
    logic [CNT_W-1:0] live_reg;
    logic [CNT_W-1:0] live_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    sample_t          max_reg;
    sample_t          max_next;

    logic [CNT_W-1:0] ws_eff;
    logic [CNT_W-1:0] live_base;
    logic [CNT_W-1:0] fill_base;
    logic [CNT_W-1:0] live_inc;
    logic             take;
    logic             emit;
    swm_ctl_t         ctl;
    sample_t          tap;

    // Handshake
    assign in_stall  = out_valid_reg & out_stall;
    assign take      = in_valid & ~in_stall;
    assign cfg_ready = 1'b1;

    // Effective window: zero acts as one, large values clip
    always_comb
    begin
        priority if (ws_reg == '0)
        begin
            ws_eff = CNT_W'(1);
        end
        else if (CNT_W'(ws_reg) > CNT_W'(WIN_MAX))
        begin
            ws_eff = CNT_W'(WIN_MAX);
        end
        else
        begin
            ws_eff = CNT_W'(ws_reg);
        end
    end

    // Live span: samples still in the window; fill: samples seen, saturating
    assign live_base = restart ? '0 : live_reg;
    assign fill_base = restart ? '0 : fill_reg;
    assign live_inc  = live_base + CNT_W'(1);
    assign live_next = (live_inc > ws_eff) ? ws_eff : live_inc;
    assign fill_next = (fill_base < ws_eff) ? fill_base + CNT_W'(1) : fill_base;
    assign emit      = (fill_next >= ws_eff);

    // Cell row: result is max of the last live_next samples
    assign ctl.shift = take;
    assign ctl.sel   = IDX_W'(live_next - CNT_W'(2));

    swm_chain u_chain (
        .clk (clk),
        .ctl (ctl),
        .x   (sample),
        .tap (tap)
    );

    assign max_next = (live_next == CNT_W'(1)) ? sample : smax(tap, sample);

    // Output register occupancy
    always_comb
    begin
        priority if (take)
        begin
            out_valid_next = emit;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg        <= WS_RESET;
            live_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                ws_reg <= window_size;
            end
            if (take)
            begin
                live_reg <= live_next;
                fill_reg <= fill_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            max_reg <= max_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign window_max = max_reg;

endmodule

// ===== tb/sv/sliding_window_maximum_unit_test.sv =====
module sliding_window_maximum_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import swm_pkg::*;

    localparam sample_t S_MIN = 32'sh8000_0000;
    localparam sample_t S_MAX = 32'sh7FFF_FFFF;
    localparam int IDLE_LIMIT = 4000;     // cycles with no word moving
    localparam int N_DIR      = 23;

    // how a directed row is checked
    typedef enum logic [1:0] {BY_MODEL, NO_WORD, GIVEN} row_kind_t;

    typedef struct packed {
        sample_t   smp;
        logic      rst;
        row_kind_t kind;
        sample_t   want;
    } dir_row_t;

    logic            clk;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_stall;
    sample_t         sample = '0;
    logic            restart = 1'b0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    sample_t         window_max;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [WS_W-1:0] cfg_window = '0;

    sliding_window_maximum_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .restart    (restart),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .window_max (window_max),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .window_size(cfg_window)
    );

    // clock, 8 ns period
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // predictor state: candidate ring, counters and the window setting
    sample_t         cand_val [WIN_MAX];
    logic [15:0]     cand_pos [WIN_MAX];
    int              cand_cnt = 0;
    int              head = 0;
    logic [15:0]     arr_cnt = '0;
    int              filled = 0;
    logic [WS_W-1:0] cur_ws = WS_RESET;

    sample_t         max_q [$];           // window maxima still to arrive
    sample_t         mon_want;
    sample_t         prev_smp = '0;
    dir_row_t        dir_rows [0:N_DIR-1];
    int              errors = 0;
    int              n_in = 0;
    int              n_out = 0;
    int              n_restart = 0;
    int              n_cfg = 0;
    int              idle_cycles = 0;
    int              stall_left = 0;
    bit              tx_calm = 1'b0;
    bit              rx_calm = 1'b0;

    // deque update for one taken word; returns 1 when the window is full
    function automatic bit predict_max(input sample_t s, input logic rs, output sample_t mx);
        int          ws;
        int          back_i;
        int          slot;
        logic [15:0] pos;
        logic [15:0] age;
        ws = (cur_ws == 0) ? 1 : ((int'(cur_ws) > WIN_MAX) ? WIN_MAX : int'(cur_ws));
        if (rs)
        begin
            cand_cnt = 0;
            head     = 0;
            arr_cnt  = '0;
            filled   = 0;
        end
        pos = arr_cnt;
        // retire aged-out front entries
        while (cand_cnt > 0)
        begin
            age = pos - cand_pos[head];
            if (int'(age) < ws)
                break;
            head = (head + 1) % WIN_MAX;
            cand_cnt--;
        end
        // pop strictly smaller back entries
        while (cand_cnt > 0)
        begin
            back_i = (head + cand_cnt - 1) % WIN_MAX;
            if (cand_val[back_i] >= s)
                break;
            cand_cnt--;
        end
        if (cand_cnt < WIN_MAX)
        begin
            slot           = (head + cand_cnt) % WIN_MAX;
            cand_val[slot] = s;
            cand_pos[slot] = pos;
            cand_cnt++;
        end
        arr_cnt = pos + 16'd1;
        if (filled < ws)
            filled++;
        mx = cand_val[head];
        return filled >= ws;
    endfunction

    // idle length: mostly short, sometimes long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    // random sample: full range, clustered, extremes, or a falling run
    function automatic sample_t gen_sample();
        int      r;
        sample_t s;
        r = $urandom_range(0, 99);
        if (r < 40)
            s = $urandom;
        else if (r < 65)
            s = sample_t'($urandom_range(0, 8)) - 4;
        else if (r < 75)
        begin
            case ($urandom_range(0, 3))
                0:       s = S_MIN;
                1:       s = S_MAX;
                2:       s = '0;
                default: s = -1;
            endcase
        end
        else
            s = prev_smp - sample_t'($urandom_range(0, 3));
        prev_smp = s;
        return s;
    endfunction

    // drive one input word and record its expected result once taken
    task automatic send_word(input sample_t s, input logic rs, input row_kind_t kind,
                             input sample_t want);
        int      gap;
        bit      has;
        sample_t mx;
        gap = 0;
        if (!tx_calm && $urandom_range(0, 9) < 3)
            gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample   <= s;
        restart  <= rs;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n_in++;
        if (rs)
            n_restart++;
        has = predict_max(s, rs, mx);
        case (kind)
            BY_MODEL: if (has) max_q = {max_q, mx};
            GIVEN:    max_q = {max_q, want};
            default:  ;
        endcase
    endtask

    // window size write, only with the block drained
    task automatic write_window(input logic [WS_W-1:0] ws);
        while (max_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_window <= ws;
        cfg_valid  <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_ws = ws;
        n_cfg++;
    endtask

    // one phase of random words under a new window size
    task automatic run_phase(input logic [WS_W-1:0] ws, input int n_words);
        int  eff;
        logic rs;
        write_window(ws);
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
        eff = (ws == 0) ? 1 : ((int'(ws) > WIN_MAX) ? WIN_MAX : int'(ws));
        for (int i = 0; i < n_words; i++)
        begin
            // first word keeps history so the size change hits a live deque
            rs = (i > 0) && ($urandom_range(0, 4 * eff + 8) == 0);
            send_word(gen_sample(), rs, BY_MODEL, '0);
        end
        in_valid <= 1'b0;
    endtask

    // result side stall pattern
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            if (!rx_calm && $urandom_range(0, 3) == 0)
                stall_left = idle_len();
        end
    end

    // result check against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            n_out++;
            if (max_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, window_max %0d, expected none",
                         $time, window_max);
            end
            else
            begin
                mon_want = max_q[0];
                max_q.delete(0);
                if (window_max !== mon_want)
                begin
                    errors++;
                    $display("%0t: window_max mismatch, expected %0d, actual %0d",
                             $time, mon_want, window_max);
                end
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        // directed rows, window of 3 after reset
        dir_rows = '{
            '{S_MIN,          1'b0, NO_WORD,  '0},
            '{S_MAX,          1'b0, NO_WORD,  '0},
            '{32'sd0,         1'b0, GIVEN,    S_MAX},
            '{32'sd5,         1'b0, GIVEN,    S_MAX},
            '{32'sd5,         1'b0, GIVEN,    32'sd5},
            '{-32'sd1,        1'b0, GIVEN,    32'sd5},
            '{-32'sd1,        1'b0, GIVEN,    32'sd5},
            '{-32'sd1,        1'b0, GIVEN,    -32'sd1},
            '{S_MIN,          1'b0, GIVEN,    -32'sd1},
            '{S_MIN,          1'b0, GIVEN,    -32'sd1},
            '{S_MIN,          1'b0, GIVEN,    S_MIN},
            '{32'sd7,         1'b1, NO_WORD,  '0},
            '{32'sd3,         1'b0, NO_WORD,  '0},
            '{32'sd9,         1'b0, GIVEN,    32'sd9},
            '{32'sd1,         1'b0, BY_MODEL, '0},
            '{32'sd2,         1'b0, BY_MODEL, '0},
            '{32'sd0,         1'b1, NO_WORD,  '0},
            '{32'sd1,         1'b1, NO_WORD,  '0},
            '{-32'sd5,        1'b0, NO_WORD,  '0},
            '{-32'sd7,        1'b0, GIVEN,    32'sd1},
            '{32'sh5555_5555, 1'b0, BY_MODEL, '0},
            '{32'shAAAA_AAAA, 1'b0, BY_MODEL, '0},
            '{-32'sd8,        1'b0, BY_MODEL, '0}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows under the reset window size
        for (int i = 0; i < N_DIR; i++)
            send_word(dir_rows[i].smp, dir_rows[i].rst, dir_rows[i].kind, dir_rows[i].want);
        in_valid <= 1'b0;

        // sizes at and beyond the limits, then random sizes
        run_phase(7'd0, 50);
        run_phase(7'd127, 130);
        run_phase(7'd1, 50);
        run_phase(7'd64, 130);
        run_phase(7'd65, 130);
        run_phase(7'd2, 50);
        run_phase(7'd3, 50);
        for (int p = 0; p < 3; p++)
        begin
            if ($urandom_range(0, 2) == 0)
                run_phase(7'($urandom_range(0, 127)), 130);
            else
                run_phase(7'($urandom_range(0, 12)), 50);
        end

        // drain, then watch for stray words
        while (max_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d input words with %0d restarts and got %0d window maxima;",
                 n_in, n_restart, n_out);
        $display("%0d window size writes covered 0, 1, 64, 65, 127 and random sizes.",
                 n_cfg);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
